FILE: hw/rtl/asis_pkg.sv
`default_nettype none

package asis_pkg;

  // field widths
  localparam int unsigned LuxW     = 24;
  localparam int unsigned SoilW    = 7;
  localparam int unsigned TempW    = 15;
  localparam int unsigned IvlW     = 14;
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned DiffTW   = TempW + 1;

  // apb register window
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam int unsigned HistDepthDef = 3;

  // interval codes in seconds
  localparam logic [IvlW-1:0] IvlMin  = 14'd600;
  localparam logic [IvlW-1:0] IvlMed  = 14'd1800;
  localparam logic [IvlW-1:0] IvlBase = 14'd3600;
  localparam logic [IvlW-1:0] IvlLong = 14'd7200;
  localparam logic [IvlW-1:0] IvlMax  = 14'd14400;

  localparam int unsigned NightShift = 2;  // night factor of 4

  localparam logic [ElapsedW-1:0] NightGuess   = 20'd36000;
  localparam logic [ElapsedW:0]   SunriseSlack = 21'd900;
  localparam logic [ElapsedW:0]   WakeOverhead = 21'd2;
  localparam logic [ElapsedW-1:0] ElapsedMax   = 20'hFFFFF;

  // register reset values
  localparam logic [LuxW-1:0]  LuxHighRst  = 24'd50000;
  localparam logic [LuxW-1:0]  LuxMedRst   = 24'd10000;
  localparam logic [LuxW-1:0]  LuxLowRst   = 24'd1000;
  localparam logic [SoilW-1:0] SoilHighRst = 7'd10;
  localparam logic [SoilW-1:0] SoilMedRst  = 7'd5;
  localparam logic [TempW-1:0] TempHighRst = 15'd300;
  localparam logic [LuxW-1:0]  NightLuxRst = 24'd1000;

  typedef enum logic [2:0] {
    REG_LUX_HIGH  = 3'd0,
    REG_LUX_MED   = 3'd1,
    REG_LUX_LOW   = 3'd2,
    REG_SOIL_HIGH = 3'd3,
    REG_SOIL_MED  = 3'd4,
    REG_TEMP_HIGH = 3'd5,
    REG_NIGHT_LUX = 3'd6,
    REG_SUNRISE   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_DAY     = 2'd1,
    PH_NIGHT   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_BASE,
    ST_LOAD,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [LuxW-1:0]  lux_high;
    logic [LuxW-1:0]  lux_med;
    logic [LuxW-1:0]  lux_low;
    logic [SoilW-1:0] soil_high;
    logic [SoilW-1:0] soil_med;
    logic [TempW-1:0] temp_high;
    logic [LuxW-1:0]  night_lux;
    logic             sunrise_en;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic diff;
    logic base;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/asis_regs.sv
`default_nettype none

module asis_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [asis_pkg::AddrW-1:0]  paddr,
  input  wire logic [asis_pkg::DataW-1:0]  pwdata,
  output logic      [asis_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output asis_pkg::cfg_t                   cfg_o
);
  import asis_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LUX_HIGH:  cfg_d.lux_high   = pwdata[LuxW-1:0];
        REG_LUX_MED:   cfg_d.lux_med    = pwdata[LuxW-1:0];
        REG_LUX_LOW:   cfg_d.lux_low    = pwdata[LuxW-1:0];
        REG_SOIL_HIGH: cfg_d.soil_high  = pwdata[SoilW-1:0];
        REG_SOIL_MED:  cfg_d.soil_med   = pwdata[SoilW-1:0];
        REG_TEMP_HIGH: cfg_d.temp_high  = pwdata[TempW-1:0];
        REG_NIGHT_LUX: cfg_d.night_lux  = pwdata[LuxW-1:0];
        REG_SUNRISE:   cfg_d.sunrise_en = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lux_high   <= LuxHighRst;
      cfg_q.lux_med    <= LuxMedRst;
      cfg_q.lux_low    <= LuxLowRst;
      cfg_q.soil_high  <= SoilHighRst;
      cfg_q.soil_med   <= SoilMedRst;
      cfg_q.temp_high  <= TempHighRst;
      cfg_q.night_lux  <= NightLuxRst;
      cfg_q.sunrise_en <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LUX_HIGH:  prdata = DataW'(cfg_q.lux_high);
      REG_LUX_MED:   prdata = DataW'(cfg_q.lux_med);
      REG_LUX_LOW:   prdata = DataW'(cfg_q.lux_low);
      REG_SOIL_HIGH: prdata = DataW'(cfg_q.soil_high);
      REG_SOIL_MED:  prdata = DataW'(cfg_q.soil_med);
      REG_TEMP_HIGH: prdata = DataW'(cfg_q.temp_high);
      REG_NIGHT_LUX: prdata = DataW'(cfg_q.night_lux);
      REG_SUNRISE:   prdata = DataW'(cfg_q.sunrise_en);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/asis_div.sv
`default_nettype none

module asis_div #(
  parameter int unsigned DividendW = 22,
  parameter int unsigned DivisorW  = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int unsigned StepsPerCycle = 2;
  // dividend padded with leading zeros to a whole number of iterations
  localparam int unsigned QW    = ((DividendW + StepsPerCycle - 1) / StepsPerCycle)
                                  * StepsPerCycle;
  localparam int unsigned Iters = QW / StepsPerCycle;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic [CntW-1:0]     cnt_q;

  // restoring division, two quotient bits per cycle
  always_comb begin
    logic [DivisorW:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < StepsPerCycle; k++) begin
      trial = {rem_d, quo_d[QW-1]};
      quo_d = {quo_d[QW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(Iters);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= QW'(dividend_i);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = (cnt_q == '0);
  assign quotient_o = quo_q[DividendW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/asis_ctrl.sv
`default_nettype none

module asis_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  asis_pkg::dp_stat_t stat_i,
  output asis_pkg::dp_cmd_t  cmd_o
);
  import asis_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        // result goes out once the divider is done and the output slot is free
        if (stat_i.div_done && (!out_valid_q || out_ready_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished result not presented");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIFF))
    else $error("accepted beat did not start processing");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/asis_dp.sv
`default_nettype none

module asis_dp #(
  parameter int unsigned HistDepth = asis_pkg::HistDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  asis_pkg::dp_cmd_t                   cmd_i,
  output asis_pkg::dp_stat_t                  stat_o,
  input  asis_pkg::cfg_t                      cfg_i,
  input  wire logic [asis_pkg::LuxW-1:0]      lux_centi_i,
  input  wire logic [asis_pkg::SoilW-1:0]     soil_percent_i,
  input  wire logic signed [asis_pkg::TempW-1:0] temp_centi_i,
  output logic [asis_pkg::IvlW-1:0]           interval_seconds_o
);
  import asis_pkg::*;

  localparam int unsigned SumW  = ElapsedW + $clog2(HistDepth);
  localparam int unsigned FillW = $clog2(HistDepth + 1);
  localparam int unsigned SlotW = (HistDepth > 1) ? $clog2(HistDepth) : 1;

  // captured measurement
  logic [LuxW-1:0]         lux_q;
  logic [SoilW-1:0]        soil_q;
  logic signed [TempW-1:0] temp_q;

  // previous measurement
  logic                    have_prev_q;
  logic [LuxW-1:0]         prev_lux_q;
  logic [SoilW-1:0]        prev_soil_q;
  logic signed [TempW-1:0] prev_temp_q;

  // change magnitudes
  logic [LuxW-1:0]   dl_q;
  logic [SoilW-1:0]  ds_q;
  logic [DiffTW-1:0] dt_q;
  logic              is_night_q;
  logic [IvlW-1:0]   ivl_q;

  // day/night tracking
  phase_e               phase_q, phase_d;
  logic [ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic [ElapsedW-1:0]  lengths_q [HistDepth];
  logic [SlotW-1:0]     slot_q;
  logic [FillW-1:0]     filled_q;
  logic [SumW-1:0]      sum_q;
  logic [IvlW-1:0]      last_q;
  logic                 hist_wr;

  logic [IvlW-1:0]      out_q;
  logic [SumW-1:0]      quotient;

  // diff stage
  logic signed [DiffTW-1:0] tdiff;
  logic [ElapsedW:0]        esum;

  assign tdiff = DiffTW'(temp_q) - DiffTW'(prev_temp_q);
  assign esum  = {1'b0, elapsed_q} + (ElapsedW + 1)'(last_q) + WakeOverhead;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lux_q  <= lux_centi_i;
      soil_q <= soil_percent_i;
      temp_q <= temp_centi_i;
    end
    if (cmd_i.diff) begin
      dl_q       <= (lux_q > prev_lux_q) ? lux_q - prev_lux_q : prev_lux_q - lux_q;
      ds_q       <= (soil_q > prev_soil_q) ? soil_q - prev_soil_q : prev_soil_q - soil_q;
      dt_q       <= tdiff[DiffTW-1] ? DiffTW'(-tdiff) : DiffTW'(tdiff);
      is_night_q <= (lux_q < cfg_i.night_lux);
    end
  end

  // base interval from the change magnitudes, then night stretch
  logic [IvlW-1:0] base_ivl;
  logic [IvlW+1:0] base_x4;
  logic [IvlW-1:0] night_ivl;

  always_comb begin
    if (!have_prev_q) begin
      base_ivl = IvlBase;
    end else begin
      if (dl_q > cfg_i.lux_high) begin
        base_ivl = IvlMin;
      end else if (dl_q > cfg_i.lux_med) begin
        base_ivl = IvlMed;
      end else if (dl_q > cfg_i.lux_low) begin
        base_ivl = IvlBase;
      end else begin
        base_ivl = IvlLong;
      end
      if (ds_q > cfg_i.soil_high) begin
        if (IvlMin < base_ivl) base_ivl = IvlMin;
      end else if (ds_q > cfg_i.soil_med) begin
        if (IvlMed < base_ivl) base_ivl = IvlMed;
      end
      if (dt_q > DiffTW'(cfg_i.temp_high)) begin
        if (IvlMed < base_ivl) base_ivl = IvlMed;
      end
    end
    base_x4   = (IvlW + 2)'(base_ivl) << NightShift;
    night_ivl = base_ivl;
    if (is_night_q) begin
      night_ivl = (base_x4 > (IvlW + 2)'(IvlMax)) ? IvlMax : base_x4[IvlW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      ivl_q <= night_ivl;
    end
  end

  // phase tracking and night accumulation
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    hist_wr   = 1'b0;
    if (cmd_i.diff && cfg_i.sunrise_en && phase_q == PH_NIGHT) begin
      elapsed_d = esum[ElapsedW] ? ElapsedMax : esum[ElapsedW-1:0];
    end
    if (cmd_i.base && cfg_i.sunrise_en) begin
      if (phase_q == PH_NIGHT && !is_night_q) begin
        hist_wr = 1'b1;
        phase_d = PH_DAY;
      end else if (phase_q != PH_NIGHT && is_night_q) begin
        phase_d   = PH_NIGHT;
        elapsed_d = '0;
      end else if (phase_q == PH_UNKNOWN && !is_night_q) begin
        phase_d = PH_DAY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_UNKNOWN;
      elapsed_q <= '0;
      slot_q    <= '0;
      filled_q  <= '0;
      sum_q     <= '0;
      for (int i = 0; i < HistDepth; i++) begin
        lengths_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      if (hist_wr) begin
        lengths_q[slot_q] <= elapsed_q;
        // running total replaces the overwritten night
        sum_q  <= sum_q - SumW'(lengths_q[slot_q]) + SumW'(elapsed_q);
        slot_q <= (slot_q == SlotW'(HistDepth - 1)) ? '0 : slot_q + 1'b1;
        if (filled_q < FillW'(HistDepth)) begin
          filled_q <= filled_q + 1'b1;
        end
      end
    end
  end

  // average night length
  asis_div #(
    .DividendW (SumW),
    .DivisorW  (FillW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (filled_q),
    .done_o     (stat_o.div_done),
    .quotient_o (quotient)
  );

  // sunrise cap and final clamp
  logic [ElapsedW-1:0] avg;
  logic [ElapsedW:0]   gap;
  logic [IvlW-1:0]     fin;

  always_comb begin
    avg = (filled_q == '0) ? NightGuess : quotient[ElapsedW-1:0];
    gap = {1'b0, avg} - {1'b0, elapsed_q} + SunriseSlack;
    fin = ivl_q;
    if (cfg_i.sunrise_en && phase_q == PH_NIGHT) begin
      if (elapsed_q < avg) begin
        if (gap < (ElapsedW + 1)'(fin)) fin = gap[IvlW-1:0];
      end else if (IvlMin < fin) begin
        fin = IvlMin;
      end
    end
    if (fin < IvlMin) fin = IvlMin;
    if (fin > IvlMax) fin = IvlMax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      last_q      <= '0;
    end else if (cmd_i.finish) begin
      have_prev_q <= 1'b1;
      last_q      <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q       <= fin;
      prev_lux_q  <= lux_q;
      prev_soil_q <= soil_q;
      prev_temp_q <= temp_q;
    end
  end

  assign interval_seconds_o = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FillW'(HistDepth))
    else $error("night history fill count out of range");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotW'(HistDepth - 1))
    else $error("night history slot out of range");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (out_q >= IvlMin && out_q <= IvlMax))
    else $error("interval outside clamp range");

endmodule

`default_nettype wire

FILE: hw/rtl/adaptive_sample_interval_scheduler.sv
// sequence: each input beat is captured, then the diff, base interval, divider load and divide
//   steps follow; the divide step uses the two-bit-per-cycle night average divider
// input: a new beat is taken only in idle, after the previous beat has finished;
//   a finished result waits in the output register while the next beat is taken
// reset: async active low; clears registers to defaults, phase unknown, history empty,
//   no previous sample
`default_nettype none

module adaptive_sample_interval_scheduler #(
  parameter int unsigned HISTORY_DEPTH = asis_pkg::HistDepthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [asis_pkg::LuxW-1:0]         lux_centi_i,
  input  wire logic [asis_pkg::SoilW-1:0]        soil_percent_i,
  input  wire logic signed [asis_pkg::TempW-1:0] temp_centi_i,
  // interval channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [asis_pkg::IvlW-1:0]              interval_seconds_o,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [asis_pkg::AddrW-1:0]        paddr,
  input  wire logic [asis_pkg::DataW-1:0]        pwdata,
  output logic [asis_pkg::DataW-1:0]             prdata,
  output logic                                   pready
);
  import asis_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // threshold and mode registers, word per register
  asis_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: capture, diff, base interval, divider load, divide and finish
  asis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // sample history, day/night tracking, night average and sunrise cap
  asis_dp #(
    .HistDepth (HISTORY_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_i              (cfg),
    .lux_centi_i        (lux_centi_i),
    .soil_percent_i     (soil_percent_i),
    .temp_centi_i       (temp_centi_i),
    .interval_seconds_o (interval_seconds_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_adaptive_sample_interval_scheduler.sv
`timescale 1ns / 1ps

module tb_adaptive_sample_interval_scheduler;
  import asis_pkg::*;

  // predictor constants, all in seconds unless noted
  localparam int unsigned Hist       = 3;
  localparam int unsigned SecShort   = 600;
  localparam int unsigned SecMid     = 1800;
  localparam int unsigned SecBase    = 3600;
  localparam int unsigned SecLong    = 7200;
  localparam int unsigned SecCap     = 14400;
  localparam int unsigned DarkFactor = 4;
  localparam int unsigned DarkGuess  = 36000;
  localparam int unsigned DawnSlack  = 900;
  localparam int unsigned WakeCost   = 2;
  localparam int unsigned DarkSat    = 32'hFFFFF;  // night time saturates at 20 bits
  localparam int          LuxTop     = 24'hFFFFFF;
  localparam int          HoldCycles = 300;         // long receiver hold-off
  localparam int          RandPhases = 7;
  localparam int          RandItems  = 250;

  // dut ports
  logic                       clk_i;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [LuxW-1:0]            lux_centi_i    = '0;
  logic [SoilW-1:0]           soil_percent_i = '0;
  logic signed [TempW-1:0]    temp_centi_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [IvlW-1:0]            interval_seconds_o;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [AddrW-1:0]           paddr          = '0;
  logic [DataW-1:0]           pwdata         = '0;
  logic [DataW-1:0]           prdata;
  logic                       pready;

  // shadow of the register file and of the block's memory of past samples
  cfg_t                       cfg_shadow;
  logic                       seen_sample;
  logic [LuxW-1:0]            prev_lux;
  logic [SoilW-1:0]           prev_soil;
  logic signed [TempW-1:0]    prev_temp;
  phase_e                     sky_phase;
  logic [ElapsedW-1:0]        dark_secs;
  logic [ElapsedW-1:0]        dark_hist [Hist];
  int unsigned                hist_slot;
  int unsigned                hist_count;
  logic [IvlW-1:0]            last_sleep;

  // expected intervals in beat order
  logic [IvlW-1:0]            pending_intervals [$];

  // run bookkeeping
  int                         samples_sent      = 0;
  int                         intervals_checked = 0;
  int                         reg_writes        = 0;
  int                         error_count       = 0;

  // idling controls, flipped by the test tasks
  bit                         tx_idle = 1'b1;
  bit                         rx_idle = 1'b1;

  // receiver state: per-beat stall, long hold-off request and its countdown
  int                         rx_wait   = 0;
  int                         hold_req  = 0;
  int                         hold_ack  = 0;
  int                         hold_left = 0;
  logic [IvlW-1:0]            rx_want;

  adaptive_sample_interval_scheduler uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .lux_centi_i        (lux_centi_i),
    .soil_percent_i     (soil_percent_i),
    .temp_centi_i       (temp_centi_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .interval_seconds_o (interval_seconds_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(64'd5_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register and sample history as they stand right after reset
  function automatic void clear_shadow();
    cfg_shadow.lux_high   = LuxHighRst;
    cfg_shadow.lux_med    = LuxMedRst;
    cfg_shadow.lux_low    = LuxLowRst;
    cfg_shadow.soil_high  = SoilHighRst;
    cfg_shadow.soil_med   = SoilMedRst;
    cfg_shadow.temp_high  = TempHighRst;
    cfg_shadow.night_lux  = NightLuxRst;
    cfg_shadow.sunrise_en = 1'b0;
    seen_sample = 1'b0;
    prev_lux    = '0;
    prev_soil   = '0;
    prev_temp   = '0;
    sky_phase   = PH_UNKNOWN;
    dark_secs   = '0;
    for (int i = 0; i < Hist; i++) dark_hist[i] = '0;
    hist_slot   = 0;
    hist_count  = 0;
    last_sleep  = '0;
  endfunction

  // next sleep interval for one measurement; advances the shadow history
  function automatic logic [IvlW-1:0] next_sleep(input logic [LuxW-1:0] lux,
                                                 input logic [SoilW-1:0] soil,
                                                 input logic signed [TempW-1:0] temp);
    int unsigned secs, dl, ds, dt, acc, sum, avg;
    int          t_now, t_old;
    bit          dark;
    dark = lux < cfg_shadow.night_lux;

    // the night clock first catches up with the sleep that just ended
    if (cfg_shadow.sunrise_en && sky_phase == PH_NIGHT) begin
      acc = dark_secs + last_sleep + WakeCost;
      dark_secs = (acc > DarkSat) ? ElapsedW'(DarkSat) : ElapsedW'(acc);
    end

    if (seen_sample) begin
      t_now = temp;
      t_old = prev_temp;
      dl = (lux > prev_lux) ? lux - prev_lux : prev_lux - lux;
      ds = (soil > prev_soil) ? soil - prev_soil : prev_soil - soil;
      dt = (t_now > t_old) ? t_now - t_old : t_old - t_now;
      if (dl > cfg_shadow.lux_high)     secs = SecShort;
      else if (dl > cfg_shadow.lux_med) secs = SecMid;
      else if (dl > cfg_shadow.lux_low) secs = SecBase;
      else                              secs = SecLong;
      if (ds > cfg_shadow.soil_high)     secs = SecShort;
      else if (ds > cfg_shadow.soil_med) secs = (secs < SecMid) ? secs : SecMid;
      if (dt > cfg_shadow.temp_high)     secs = (secs < SecMid) ? secs : SecMid;
    end else begin
      secs = SecBase;
    end

    if (dark) secs = (secs * DarkFactor < SecCap) ? secs * DarkFactor : SecCap;

    if (cfg_shadow.sunrise_en) begin
      if (sky_phase == PH_NIGHT && !dark) begin
        // dawn: log the night that just ended
        dark_hist[hist_slot] = dark_secs;
        hist_slot = (hist_slot + 1) % Hist;
        if (hist_count < Hist) hist_count++;
        sky_phase = PH_DAY;
      end else if (sky_phase != PH_NIGHT && dark) begin
        sky_phase = PH_NIGHT;
        dark_secs = '0;
      end else if (sky_phase == PH_UNKNOWN && !dark) begin
        sky_phase = PH_DAY;
      end
      if (sky_phase == PH_NIGHT) begin
        if (hist_count == 0) begin
          avg = DarkGuess;
        end else begin
          sum = 0;
          for (int i = 0; i < hist_count; i++) sum += dark_hist[i];
          avg = sum / hist_count;
        end
        // wake no later than shortly after the expected sunrise
        if (dark_secs < avg) begin
          acc = avg - dark_secs + DawnSlack;
          secs = (secs < acc) ? secs : acc;
        end else begin
          secs = (secs < SecShort) ? secs : SecShort;
        end
      end
    end

    if (secs < SecShort) secs = SecShort;
    if (secs > SecCap)   secs = SecCap;

    prev_lux    = lux;
    prev_soil   = soil;
    prev_temp   = temp;
    seen_sample = 1'b1;
    last_sleep  = IvlW'(secs);
    return IvlW'(secs);
  endfunction

  // ---------------------------------------------------------------------------
  // bus helpers
  // ---------------------------------------------------------------------------

  // one sample beat; valid stays up afterwards so back-to-back beats need no bubble
  task automatic send_sample(input logic [LuxW-1:0] lux, input logic [SoilW-1:0] soil,
                             input logic signed [TempW-1:0] temp);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    lux_centi_i    <= lux;
    soil_percent_i <= soil;
    temp_centi_i   <= temp;
    do @(posedge clk_i); while (!in_ready_o);
    pending_intervals.push_back(next_sleep(lux, soil, temp));
    samples_sent++;
  endtask

  // drop valid and let every outstanding interval come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_intervals.size() != 0);
  endtask

  // apb write: setup, access, then the bus returns to idle
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LUX_HIGH:  cfg_shadow.lux_high   = value[LuxW-1:0];
      REG_LUX_MED:   cfg_shadow.lux_med    = value[LuxW-1:0];
      REG_LUX_LOW:   cfg_shadow.lux_low    = value[LuxW-1:0];
      REG_SOIL_HIGH: cfg_shadow.soil_high  = value[SoilW-1:0];
      REG_SOIL_MED:  cfg_shadow.soil_med   = value[SoilW-1:0];
      REG_TEMP_HIGH: cfg_shadow.temp_high  = value[TempW-1:0];
      REG_NIGHT_LUX: cfg_shadow.night_lux  = value[LuxW-1:0];
      REG_SUNRISE:   cfg_shadow.sunrise_en = value[0];
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DataW-1:0] lux_hi, input logic [DataW-1:0] lux_md,
                            input logic [DataW-1:0] lux_lo, input logic [DataW-1:0] soil_hi,
                            input logic [DataW-1:0] soil_md, input logic [DataW-1:0] temp_hi,
                            input logic [DataW-1:0] night, input logic [DataW-1:0] sunrise);
    write_reg(REG_LUX_HIGH,  lux_hi);
    write_reg(REG_LUX_MED,   lux_md);
    write_reg(REG_LUX_LOW,   lux_lo);
    write_reg(REG_SOIL_HIGH, soil_hi);
    write_reg(REG_SOIL_MED,  soil_md);
    write_reg(REG_TEMP_HIGH, temp_hi);
    write_reg(REG_NIGHT_LUX, night);
    write_reg(REG_SUNRISE,   sunrise);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and interval checker
  // ---------------------------------------------------------------------------

  // ready drops for a drawn number of cycles once the next interval shows up,
  // and for a long stretch whenever a test asks for a hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        intervals_checked++;
        if (pending_intervals.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("interval beat with nothing pending: got %0d", interval_seconds_o);
        end else begin
          rx_want = pending_intervals.pop_front();
          if (interval_seconds_o !== rx_want) begin
            error_count++;
            if (error_count <= 10)
              $display("interval_seconds wrong on beat %0d: expected %0d, got %0d",
                       intervals_checked, rx_want, interval_seconds_o);
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HoldCycles;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_i <= (hold_left == 0) && (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // no previous sample yet, so the base interval comes out whatever the change
  task automatic test_first_sample();
    send_sample(24'd20000, 7'd40, 15'sd2000);
  endtask

  // field extremes, out-of-range soil and raw temperature patterns
  task automatic test_field_extremes();
    send_sample(24'hFFFFFF, 7'd100, 15'sd13000);
    send_sample(24'hFFFFFF, 7'd100, 15'sd13000);   // no change at all
    send_sample(24'd0,      7'd0,   -15'sd4500);   // huge drop into the night
    send_sample(24'd0,      7'd127, 15'sh3FFF);    // largest positive pattern
    send_sample(24'hFFFFFF, 7'd127, 15'sh4000);    // most negative pattern
    send_sample(24'hFFFFFF, 7'd127, 15'sh4000);
  endtask

  // every comparison is strict: a change equal to the threshold keeps the tier
  task automatic test_thresholds();
    send_sample(24'd100000, 7'd50, 15'sd0);
    send_sample(24'd101000, 7'd50, 15'sd0);   // lux change at the low threshold
    send_sample(24'd102001, 7'd50, 15'sd0);   // one above it
    send_sample(24'd112001, 7'd50, 15'sd0);   // at the medium threshold
    send_sample(24'd122002, 7'd50, 15'sd0);   // one above it
    send_sample(24'd172002, 7'd50, 15'sd0);   // at the high threshold
    send_sample(24'd222003, 7'd50, 15'sd0);   // one above it
    send_sample(24'd222003, 7'd55, 15'sd0);   // soil at the medium threshold
    send_sample(24'd222003, 7'd61, 15'sd0);   // one above it
    send_sample(24'd222003, 7'd71, 15'sd0);   // soil at the high threshold
    send_sample(24'd222003, 7'd82, 15'sd0);   // one above it
    send_sample(24'd222003, 7'd82, 15'sd300); // temperature at its threshold
    send_sample(24'd222003, 7'd82, 15'sd601); // one above it
    send_sample(24'd222003, 7'd82, 15'sd300); // same step downwards
  endtask

  // one night on the default guess, running past the expected sunrise, then a
  // short night that already averages over the logged one
  task automatic test_sunrise_tracking();
    wait_idle();
    write_reg(REG_SUNRISE, 32'd1);
    send_sample(24'd20000, 7'd40, 15'sd2000);
    repeat (5) send_sample(24'd500, 7'd40, 15'sd2000);
    send_sample(24'd30000, 7'd40, 15'sd2000);
    repeat (3) send_sample(24'd100, 7'd41, 15'sd1900);
    send_sample(24'd40000, 7'd41, 15'sd1900);
  endtask

  // tracking off in the middle of a night keeps phase, clock and history frozen
  task automatic test_tracking_hold();
    repeat (3) send_sample(24'd200, 7'd30, 15'sd1000);
    wait_idle();
    write_reg(REG_SUNRISE, 32'd0);
    repeat (3) send_sample(24'd300, 7'd30, 15'sd1000);
    repeat (2) send_sample(24'd9000, 7'd31, 15'sd1000);
    send_sample(24'd400, 7'd31, 15'sd1000);
    wait_idle();
    write_reg(REG_SUNRISE, 32'd1);
    repeat (3) send_sample(24'd400, 7'd31, 15'sd1000);
    send_sample(24'd25000, 7'd31, 15'sd1000);
  endtask

  // one very long night drives the night clock into saturation; the logged
  // length then dominates the average while a few short nights rotate the slots
  task automatic test_night_saturation();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (1800)
      send_sample(24'($urandom_range(0, 999)), 7'($urandom_range(0, 100)),
                  15'(int'($urandom_range(0, 17500)) - 4500));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_sample(24'd50000, 7'd50, 15'sd2000);
    repeat (3) begin
      repeat (4) send_sample(24'($urandom_range(0, 999)), 7'd50, 15'sd2000);
      repeat (2) send_sample(24'($urandom_range(1000, 90000)), 7'd50, 15'sd2000);
    end
  endtask

  // all registers at zero, then all bits set, then back to the reset values
  task automatic test_register_extremes();
    wait_idle();
    set_config('0, '0, '0, '0, '0, '0, '0, '0);
    repeat (8)
      send_sample(24'($urandom()), 7'($urandom_range(0, 127)), 15'($urandom()));
    wait_idle();
    set_config('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (6)
      send_sample(24'($urandom()), 7'($urandom_range(0, 127)), 15'($urandom()));
    send_sample(24'hFFFFFF, 7'd0, 15'sd0);   // only full scale escapes the night
    repeat (3)
      send_sample(24'($urandom()), 7'($urandom_range(0, 127)), 15'($urandom()));
    wait_idle();
    set_config(LuxHighRst, LuxMedRst, LuxLowRst, SoilHighRst, SoilMedRst, TempHighRst,
               NightLuxRst, 32'd0);
  endtask

  // receiver holds off while samples keep coming, so the block backs up and
  // stalls its input; afterwards the sender waits for a full drain
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_req <= hold_req + 1;
    repeat (20)
      send_sample(24'($urandom_range(0, 200000)), 7'($urandom_range(0, 100)),
                  15'(int'($urandom_range(0, 17500)) - 4500));
    wait_idle();
    tx_idle = 1'b1;
    repeat (5)
      send_sample(24'($urandom_range(0, 200000)), 7'($urandom_range(0, 100)),
                  15'(int'($urandom_range(0, 17500)) - 4500));
  endtask

  // random walks through day/night runs under several register settings;
  // most steps land near the thresholds, a few are pure noise
  task automatic test_random();
    int          lux_walk, soil_walk, temp_walk, run_left;
    int unsigned sel, span, lo, md;
    bit          dark;
    lux_walk  = 50000;
    soil_walk = 50;
    temp_walk = 2000;
    run_left  = 0;
    dark      = 1'b1;
    for (int p = 0; p < RandPhases; p++) begin
      wait_idle();
      if (p == RandPhases - 1) begin
        // every bit of every register, upper pwdata bits included
        set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
      end else if (p != 0) begin
        lo = $urandom_range(0, 4000);
        md = lo + $urandom_range(0, 30000);
        sel = $urandom_range(0, 25);
        set_config(md + $urandom_range(0, 150000), md, lo, sel, $urandom_range(0, sel),
                   $urandom_range(0, 1500), $urandom_range(0, 20000), p % 2);
      end
      tx_idle = (p % 3) != 0;
      rx_idle = (p % 4) != 1;
      for (int k = 0; k < RandItems; k++) begin
        if (run_left == 0) begin
          dark     = !dark;
          run_left = $urandom_range(2, 40);
        end
        run_left--;

        sel  = $urandom_range(0, 9);
        span = (sel < 3) ? cfg_shadow.lux_low :
               (sel < 5) ? cfg_shadow.lux_med :
               (sel < 7) ? cfg_shadow.lux_high : 64;
        if (sel == 9) begin
          lux_walk = $urandom_range(0, LuxTop);
        end else begin
          lux_walk = lux_walk + int'($urandom_range(0, 2 * span + 2)) - int'(span) - 1;
          if (lux_walk < 0)      lux_walk = 0;
          if (lux_walk > LuxTop) lux_walk = LuxTop;
          // keep to the side of the night level that the current run wants
          if (dark && cfg_shadow.night_lux != 0 && lux_walk >= int'(cfg_shadow.night_lux))
            lux_walk = $urandom_range(0, cfg_shadow.night_lux - 1);
          else if (!dark && lux_walk < int'(cfg_shadow.night_lux))
            lux_walk = cfg_shadow.night_lux + $urandom_range(0, 3 * cfg_shadow.lux_low + 10);
          if (lux_walk > LuxTop) lux_walk = LuxTop;
        end

        if ($urandom_range(0, 19) == 0) begin
          soil_walk = $urandom_range(0, 127);
        end else begin
          soil_walk = soil_walk + int'($urandom_range(0, 2 * cfg_shadow.soil_high + 2))
                      - int'(cfg_shadow.soil_high) - 1;
          if (soil_walk < 0)   soil_walk = 0;
          if (soil_walk > 100) soil_walk = 100;
        end

        if ($urandom_range(0, 19) == 0) begin
          temp_walk = int'($urandom_range(0, 32767)) - 16384;
        end else begin
          temp_walk = temp_walk + int'($urandom_range(0, 2 * cfg_shadow.temp_high + 2))
                      - int'(cfg_shadow.temp_high) - 1;
          if (temp_walk < -4500) temp_walk = -4500;
          if (temp_walk > 13000) temp_walk = 13000;
        end

        send_sample(24'(lux_walk), 7'(soil_walk), 15'(temp_walk));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_sample();
    test_field_extremes();
    test_thresholds();
    test_sunrise_tracking();
    test_tracking_hold();
    test_night_saturation();
    test_register_extremes();
    test_backpressure();
    test_random();

    // let the tail drain, bounded, then give the block time to misbehave
    in_valid_i <= 1'b0;
    for (int n = 0; n < 5000 && pending_intervals.size() != 0; n++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    error_count += pending_intervals.size();

    $display("run covered %0d samples, %0d interval beats, %0d register writes",
             samples_sent, intervals_checked, reg_writes);
    $display("thresholds, night scaling, sunrise cap and saturation, hold-off, %0d settings",
             RandPhases);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
